FILE: hw/rtl/bfsa_pkg.sv
`default_nettype none
package bfsa_pkg;
	localparam int SLOT_COUNT = 16;
	localparam int IDX_W = $clog2(SLOT_COUNT);

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOFIT    = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic        command;
		logic [31:0] request_size;
		logic [31:0] align_bytes;
		logic [31:0] free_offset;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] grant_offset;
		logic [30:0] grant_padding;
		logic [31:0] grant_size;
		logic [3:0]  slot_index;
	} rsp_t;

	typedef struct packed {
		logic [31:0] start;
		logic [31:0] length;
		logic        busy;
	} slot_t;
endpackage
`default_nettype wire

FILE: hw/rtl/bfsa_if.sv
`default_nettype none
interface bfsa_req_if;
	logic           valid;
	logic           ready;
	bfsa_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bfsa_rsp_if;
	logic           valid;
	logic           ready;
	bfsa_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/best_fit_segment_allocator_top.sv
`default_nettype none
// channel   dir  handshake      payload
// req       in   valid/ready    command, request_size, align_bytes, free_offset
// rsp       out  valid/ready    status, grant_offset, grant_padding, grant_size, slot_index
// cfg       in   cfg_we         cfg_data = pool_capacity
// One request at a time through a sequencer over a one-read, one-write slot table.
// Allocate: a full scan of the slots, then split/shift; free: a scan, then merge.
// Reset and cfg writes re-init the table. req is not ready while busy or while a
// response waits on a stalled rsp.
module best_fit_segment_allocator_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_data,
	bfsa_req_if.sink         req,
	bfsa_rsp_if.source       rsp
);
	localparam int N = bfsa_pkg::SLOT_COUNT;
	localparam int W = bfsa_pkg::IDX_W;
	localparam logic [W-1:0] LAST = W'(N - 1);

	typedef enum logic [3:0] {
		IDLE, A_SCAN, A_CHK, A_NX, A_LAST, A_SHIFT, A_WNX, A_WBEST,
		F_SCAN, F_RIGHT, F_RZERO, F_LEFT, F_LWR, F_IZ
	} state_t;

	state_t state_q;
	bfsa_pkg::slot_t tbl_q [N];
	logic [31:0] cap_q;
	logic [W-1:0] cnt_q, best_q, left_q;
	logic [31:0] size_q, mask_q, off_q;
	logic [32:0] blen_q;
	logic [31:0] bstart_q, bpad_q;
	logic found_q, shifted_q, nx_busy_q;
	logic [31:0] idx_len_q, idx_start_q, left_len_q, prev_start_q, prev_len_q;
	logic rsp_valid_q;
	bfsa_pkg::rsp_t rsp_q;

	bfsa_pkg::slot_t rd;
	logic [31:0] rd_pad, need, eff, req_mask;
	logic fit;
	logic wr_en, en_s, en_l, en_b;
	logic [W-1:0] wr_addr;
	bfsa_pkg::slot_t wr;

	assign rd = tbl_q[cnt_q];
	assign rd_pad = (32'd0 - rd.start) & mask_q;
	assign fit = !rd.busy && ({1'b0, rd.length} < blen_q)
		&& ({1'b0, size_q} + {1'b0, rd_pad} <= {1'b0, rd.length});
	assign need = size_q + bpad_q;
	assign eff = req.data.align_bytes & (32'd0 - req.data.align_bytes);
	assign req_mask = (eff == 32'd0) ? 32'd0 : eff - 32'd1;

	assign req.ready = (state_q == IDLE) && !rsp_valid_q;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_q;

	always_comb begin
		wr_en = 1'b0;
		en_s = 1'b0;
		en_l = 1'b0;
		en_b = 1'b0;
		wr_addr = cnt_q;
		wr = rd;
		unique case (state_q)
			A_SHIFT: begin
				wr_en = 1'b1; en_s = 1'b1; en_l = 1'b1; en_b = 1'b1;
				wr_addr = cnt_q + W'(1);
			end
			A_WNX: begin
				wr_en = 1'b1; en_s = 1'b1; en_l = 1'b1; en_b = 1'b1;
				wr_addr = best_q + W'(1);
				wr.start = bstart_q + need;
				wr.length = blen_q[31:0] - need;
				wr.busy = shifted_q ? 1'b0 : nx_busy_q;
			end
			A_WBEST: begin
				wr_en = 1'b1; en_l = 1'b1; en_b = 1'b1;
				wr_addr = best_q;
				wr.length = need;
				wr.busy = 1'b1;
			end
			F_SCAN: begin
				wr_en = (rd.start == off_q);
				en_b = 1'b1;
				wr.busy = 1'b0;
			end
			F_RIGHT: begin
				wr_en = !rd.busy && (rd.length != 32'd0);
				en_l = 1'b1;
				wr_addr = best_q;
				wr.length = idx_len_q + rd.length;
			end
			F_RZERO, F_IZ: begin
				// absorbed right neighbor is always cleared; freed slot only when it merged into a left neighbor
				wr_en = (state_q == F_RZERO) || (left_q != best_q);
				en_l = 1'b1;
				wr_addr = (state_q == F_RZERO) ? best_q + W'(1) : best_q;
				wr.length = 32'd0;
			end
			F_LWR: begin
				wr_en = 1'b1; en_l = 1'b1;
				en_s = (left_q != '0);
				wr_addr = left_q;
				wr.length = left_len_q + idx_len_q;
				wr.start = prev_start_q + prev_len_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				tbl_q[i] <= '{start: 32'd0, length: 32'd0, busy: 1'b0};
			end
		end else if (cfg_we) begin
			for (int i = 0; i < N; i++) begin
				tbl_q[i] <= '{start: (i == 0) ? 32'd0 : cfg_data,
					length: (i == 0) ? cfg_data : 32'd0, busy: 1'b0};
			end
		end else if (wr_en) begin
			if (en_s) tbl_q[wr_addr].start <= wr.start;
			if (en_l) tbl_q[wr_addr].length <= wr.length;
			if (en_b) tbl_q[wr_addr].busy <= wr.busy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			rsp_valid_q <= 1'b0;
			cap_q <= 32'd0;
			cnt_q <= '0;
		end else begin
			if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
			if (cfg_we) cap_q <= cfg_data;
			unique case (state_q)
				IDLE: begin
					if (req.valid && req.ready) begin
						size_q <= req.data.request_size;
						mask_q <= req_mask;
						off_q <= req.data.free_offset;
						blen_q <= '1;
						found_q <= 1'b0;
						shifted_q <= 1'b0;
						cnt_q <= '0;
						if (req.data.command == bfsa_pkg::CMD_FREE) begin
							state_q <= F_SCAN;
						end else if (req.data.request_size == 32'd0
							|| req.data.request_size > cap_q) begin
							rsp_q <= '{status: bfsa_pkg::ST_NOFIT, default: '0};
							rsp_valid_q <= 1'b1;
						end else begin
							state_q <= A_SCAN;
						end
					end
				end
				A_SCAN: begin
					if (fit) begin
						found_q <= 1'b1;
						best_q <= cnt_q;
						blen_q <= {1'b0, rd.length};
						bstart_q <= rd.start;
						bpad_q <= rd_pad;
					end
					cnt_q <= cnt_q + W'(1);
					if (cnt_q == LAST) state_q <= A_CHK;
				end
				A_CHK: begin
					if (!found_q) begin
						rsp_q <= '{status: bfsa_pkg::ST_NOFIT, default: '0};
						rsp_valid_q <= 1'b1;
						state_q <= IDLE;
					end else if ({1'b0, need} < blen_q) begin
						if (best_q == LAST) begin
							rsp_q <= '{status: bfsa_pkg::ST_FULL, default: '0};
							rsp_valid_q <= 1'b1;
							state_q <= IDLE;
						end else begin
							cnt_q <= best_q + W'(1);
							state_q <= A_NX;
						end
					end else begin
						state_q <= A_WBEST;
					end
				end
				A_NX: begin
					nx_busy_q <= rd.busy;
					if (rd.length == 32'd0) begin
						state_q <= A_WNX;
					end else begin
						cnt_q <= LAST;
						state_q <= A_LAST;
					end
				end
				A_LAST: begin
					if (rd.length != 32'd0) begin
						rsp_q <= '{status: bfsa_pkg::ST_FULL, default: '0};
						rsp_valid_q <= 1'b1;
						state_q <= IDLE;
					end else begin
						shifted_q <= 1'b1;
						cnt_q <= LAST - W'(1);
						state_q <= A_SHIFT;
					end
				end
				A_SHIFT: begin
					if (cnt_q == best_q + W'(1)) state_q <= A_WNX;
					else cnt_q <= cnt_q - W'(1);
				end
				A_WNX: state_q <= A_WBEST;
				A_WBEST: begin
					rsp_q <= '{status: bfsa_pkg::ST_OK, grant_offset: bstart_q,
						grant_padding: bpad_q[30:0], grant_size: size_q,
						slot_index: 4'(best_q)};
					rsp_valid_q <= 1'b1;
					state_q <= IDLE;
				end
				F_SCAN: begin
					if (rd.start == off_q) begin
						best_q <= cnt_q;
						left_q <= cnt_q;
						idx_len_q <= rd.length;
						idx_start_q <= rd.start;
						if (cnt_q == LAST) begin
							cnt_q <= cnt_q - W'(1);
							state_q <= F_LEFT;
						end else begin
							cnt_q <= cnt_q + W'(1);
							state_q <= F_RIGHT;
						end
					end else if (off_q < rd.start || cnt_q == LAST) begin
						rsp_q <= '{status: bfsa_pkg::ST_NOTFOUND, default: '0};
						rsp_valid_q <= 1'b1;
						state_q <= IDLE;
					end else begin
						cnt_q <= cnt_q + W'(1);
					end
				end
				F_RIGHT: begin
					if (!rd.busy && rd.length != 32'd0) begin
						idx_len_q <= idx_len_q + rd.length;
						state_q <= F_RZERO;
					end else if (best_q == '0) begin
						state_q <= F_IZ;
						left_q <= best_q;
					end else begin
						cnt_q <= best_q - W'(1);
						state_q <= F_LEFT;
					end
				end
				F_RZERO: begin
					cnt_q <= best_q - W'(1);
					state_q <= (best_q == '0) ? F_IZ : F_LEFT;
				end
				F_LEFT: begin
					if (rd.busy) begin
						prev_start_q <= rd.start;
						prev_len_q <= rd.length;
						state_q <= (left_q != best_q) ? F_LWR : F_IZ;
					end else begin
						left_q <= cnt_q;
						left_len_q <= rd.length;
						if (cnt_q == '0) state_q <= F_LWR;
						else cnt_q <= cnt_q - W'(1);
					end
				end
				F_LWR: state_q <= F_IZ;
				F_IZ: begin
					rsp_q <= '{status: bfsa_pkg::ST_OK, grant_offset: idx_start_q,
						grant_padding: 31'd0, grant_size: 32'd0,
						slot_index: 4'(best_q)};
					rsp_valid_q <= 1'b1;
					state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
